/* src/cphex_pkg.sv */
// Package for the content pattern escaper: character codes, result kinds, helper functions.
package cphex_pkg;

    // Character codes used by the escaper
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOWX   = 8'h78;

    // Pair tracking codes
    localparam logic [1:0] PHASE_NONE  = 2'd0;
    localparam logic [1:0] PHASE_DIGIT = 2'd1;
    localparam logic [1:0] PHASE_SPACE = 2'd2;

    // Result kinds
    localparam logic KIND_CHAR   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam int unsigned ESC_LEN = 4;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef logic [ESC_LEN-1:0][7:0] char_vec_t;

    // Upper-case hex character for one nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10)
        begin
            r = 8'h30 + {4'd0, nib};
        end
        else
        begin
            r = 8'h37 + {4'd0, nib};
        end
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

endpackage

/* src/content_pattern_to_hex_escape.sv */
// Top level of the content pattern escaper: decode, result queue and output register.
//
// Usage: pattern bytes enter on the in channel (in_valid/in_ready, in_byte, in_last),
// one transaction per byte, in_last high on the final byte. Results leave on the out
// channel (out_valid/out_ready) one per transaction: item_kind 0 carries one escaped
// character in out_byte, item_kind 1 is the end-of-pattern status with fail and
// byte_count. run_last marks the final result caused by one input byte.
// Each byte is decoded in the cycle it is accepted and its results (0, 1, 2, 4 or 5)
// go into a job register; the output register then takes one result per cycle
// while the receiver is ready. The results of a byte pass through the job register
// and then the output register. The output port carries one result per cycle when
// the receiver does not stall; a byte that yields no result leaves the job register
// empty. The next byte is accepted in the cycle the last result of the current
// byte moves into the output register.
// Reset clears the pattern state (group mode, pending pair, count, error) and
// empties both registers. When the receiver stalls, the output register holds its
// result, the job register fills and in_ready drops until space frees up.
module content_pattern_to_hex_escape
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        item_kind,
    output logic [7:0]  out_byte,
    output logic        run_last,
    output logic        fail,
    output logic [15:0] byte_count
);

    // Pattern state
    logic        in_group_reg,    in_group_next;
    logic [1:0]  pair_phase_reg,  pair_phase_next;
    logic [7:0]  first_digit_reg, first_digit_next;
    logic [15:0] count_reg,       count_next;
    logic        error_reg,       error_next;
    logic        at_start_reg,    at_start_next;

    // Job register: results of one accepted byte
    logic                   job_valid_reg,  job_valid_next;
    logic [2:0]             job_total_reg,  job_total_next;
    logic [2:0]             job_idx_reg,    job_idx_next;
    logic [2:0]             job_nchar_reg,  job_nchar_next;
    cphex_pkg::char_vec_t   job_chars_reg,  job_chars_next;
    logic                   job_fail_reg,   job_fail_next;
    logic [15:0]            job_count_reg,  job_count_next;

    // Output register
    logic        out_valid_reg,  out_valid_next;
    logic        out_kind_reg,   out_kind_next;
    logic [7:0]  out_byte_reg,   out_byte_next;
    logic        out_last_reg,   out_last_next;
    logic        out_fail_reg,   out_fail_next;
    logic [15:0] out_count_reg,  out_count_next;

    // Decode results for the byte at the input
    logic                 dec_take;
    logic [2:0]           dec_nchar;
    cphex_pkg::char_vec_t dec_chars;
    logic                 dec_fail;
    logic [15:0]          dec_count;
    logic [15:0]          cnt_bump;

    logic out_load;
    logic job_done;
    logic in_fire;

    assign out_load = job_valid_reg && (!out_valid_reg || out_ready);
    assign job_done = out_load && (job_idx_reg == job_total_reg - 3'd1);
    assign in_ready = !job_valid_reg || job_done;
    assign in_fire  = in_valid && in_ready;

    assign cnt_bump = (count_reg == cphex_pkg::COUNT_MAX) ? count_reg : count_reg + 16'd1;

    // Byte decode and next pattern state
    always_comb
    begin
        in_group_next    = in_group_reg;
        pair_phase_next  = pair_phase_reg;
        first_digit_next = first_digit_reg;
        count_next       = count_reg;
        error_next       = error_reg;
        at_start_next    = at_start_reg;
        dec_take         = 1'b0;
        dec_nchar        = 3'd0;
        dec_chars        = '0;
        dec_fail         = 1'b0;
        dec_count        = 16'd0;

        if (in_fire)
        begin
            if (!error_reg)
            begin
                if ((pair_phase_reg == cphex_pkg::PHASE_DIGIT) && (in_byte == cphex_pkg::CH_SPACE))
                begin
                    if (in_last)
                    begin
                        error_next = 1'b1;
                    end
                    else
                    begin
                        pair_phase_next = cphex_pkg::PHASE_SPACE;
                    end
                end
                else if (pair_phase_reg != cphex_pkg::PHASE_NONE)
                begin
                    // Pair completes: \x plus both characters as written
                    dec_nchar       = 3'd4;
                    dec_chars       = {in_byte, first_digit_reg,
                                       cphex_pkg::CH_LOWX, cphex_pkg::CH_BSLASH};
                    count_next      = cnt_bump;
                    pair_phase_next = cphex_pkg::PHASE_NONE;
                end
                else if ((at_start_reg || in_last) && (in_byte == cphex_pkg::CH_QUOTE))
                begin
                    // Enclosing quote dropped
                end
                else if (!in_group_reg)
                begin
                    if (cphex_pkg::is_alnum(in_byte))
                    begin
                        dec_nchar  = 3'd1;
                        dec_chars  = {24'd0, in_byte};
                        count_next = cnt_bump;
                    end
                    else if (in_byte == cphex_pkg::CH_BAR)
                    begin
                        in_group_next = 1'b1;
                    end
                    else
                    begin
                        dec_nchar  = 3'd4;
                        dec_chars  = {cphex_pkg::hex_char(in_byte[3:0]),
                                      cphex_pkg::hex_char(in_byte[7:4]),
                                      cphex_pkg::CH_LOWX, cphex_pkg::CH_BSLASH};
                        count_next = cnt_bump;
                    end
                end
                else
                begin
                    if (cphex_pkg::is_hex(in_byte))
                    begin
                        if (in_last)
                        begin
                            error_next = 1'b1;
                        end
                        else
                        begin
                            first_digit_next = in_byte;
                            pair_phase_next  = cphex_pkg::PHASE_DIGIT;
                        end
                    end
                    else if ((in_byte == cphex_pkg::CH_SPACE) || (in_byte == cphex_pkg::CH_TAB))
                    begin
                        // Blank inside a group is eaten
                    end
                    else if (in_byte == cphex_pkg::CH_BAR)
                    begin
                        in_group_next = 1'b0;
                    end
                    else
                    begin
                        error_next = 1'b1;
                    end
                end
            end
            at_start_next = 1'b0;
            dec_take      = in_last || (dec_nchar != 3'd0);

            // Status uses the state before the end-of-pattern reset
            dec_fail  = error_next;
            dec_count = count_next;

            // Pattern end: back to the reset state
            if (in_last)
            begin
                in_group_next    = 1'b0;
                pair_phase_next  = cphex_pkg::PHASE_NONE;
                first_digit_next = 8'd0;
                count_next       = 16'd0;
                error_next       = 1'b0;
                at_start_next    = 1'b1;
            end
        end
    end

    // Job register control
    always_comb
    begin
        job_valid_next = job_valid_reg;
        job_total_next = job_total_reg;
        job_idx_next   = job_idx_reg;
        job_nchar_next = job_nchar_reg;
        job_chars_next = job_chars_reg;
        job_fail_next  = job_fail_reg;
        job_count_next = job_count_reg;

        if (out_load)
        begin
            job_idx_next = job_idx_reg + 3'd1;
        end
        if (job_done)
        begin
            job_valid_next = 1'b0;
        end
        if (dec_take)
        begin
            job_valid_next = 1'b1;
            job_idx_next   = 3'd0;
            job_nchar_next = dec_nchar;
            job_total_next = dec_nchar + {2'd0, in_last};
            job_chars_next = dec_chars;
            job_fail_next  = dec_fail;
            job_count_next = dec_fail ? 16'd0 : dec_count;
        end
    end

    // Output register control
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_fail_next  = out_fail_reg;
        out_count_next = out_count_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_last_next  = (job_idx_reg == job_total_reg - 3'd1);
            if (job_idx_reg < job_nchar_reg)
            begin
                out_kind_next  = cphex_pkg::KIND_CHAR;
                out_byte_next  = job_chars_reg[job_idx_reg[1:0]];
                out_fail_next  = 1'b0;
                out_count_next = 16'd0;
            end
            else
            begin
                out_kind_next  = cphex_pkg::KIND_STATUS;
                out_byte_next  = 8'd0;
                out_fail_next  = job_fail_reg;
                out_count_next = job_count_reg;
            end
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_group_reg    <= 1'b0;
            pair_phase_reg  <= cphex_pkg::PHASE_NONE;
            first_digit_reg <= 8'd0;
            count_reg       <= 16'd0;
            error_reg       <= 1'b0;
            at_start_reg    <= 1'b1;
            job_valid_reg   <= 1'b0;
            job_idx_reg     <= 3'd0;
            job_total_reg   <= 3'd0;
            job_nchar_reg   <= 3'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            in_group_reg    <= in_group_next;
            pair_phase_reg  <= pair_phase_next;
            first_digit_reg <= first_digit_next;
            count_reg       <= count_next;
            error_reg       <= error_next;
            at_start_reg    <= at_start_next;
            job_valid_reg   <= job_valid_next;
            job_idx_reg     <= job_idx_next;
            job_total_reg   <= job_total_next;
            job_nchar_reg   <= job_nchar_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        job_chars_reg <= job_chars_next;
        job_fail_reg  <= job_fail_next;
        job_count_reg <= job_count_next;
        out_kind_reg  <= out_kind_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        out_fail_reg  <= out_fail_next;
        out_count_reg <= out_count_next;
    end

    assign out_valid  = out_valid_reg;
    assign item_kind  = out_kind_reg;
    assign out_byte   = out_byte_reg;
    assign run_last   = out_last_reg;
    assign fail       = out_fail_reg;
    assign byte_count = out_count_reg;

    // A job with results still to send is never overwritten
    a_job_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid_reg && !job_done) |-> !in_ready)
        else $error("job register overwritten before drained");

    // The result index stays inside the job
    a_job_idx: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg |-> (job_idx_reg < job_total_reg))
        else $error("job index beyond job length");

    // A status result always closes the results of its byte
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_kind_reg == cphex_pkg::KIND_STATUS)) |-> out_last_reg)
        else $error("status result not marked last");

    // A failing status carries no count
    a_fail_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_fail_reg) |-> (out_count_reg == 16'd0))
        else $error("failing status with nonzero count");

    // Pattern end leaves the decoder in its start state
    a_end_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_last) |=> (at_start_reg && !error_reg && (count_reg == 16'd0)
                                  && (pair_phase_reg == cphex_pkg::PHASE_NONE)))
        else $error("state not cleared after pattern end");

endmodule
